/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off during reset.
`define CHECK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check with an antecedent and a consequent in the cycle after it.
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Widths, limits and codes of the sphere mesh midpoint subdivider.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int IDX_W     = 14;
    localparam int NEXT_W    = IDX_W + 1;
    localparam int CRD_W     = 16;
    localparam int SUM_W     = CRD_W + 1;
    localparam int TBL_DEPTH = 2048;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CNT_W     = TBL_AW + 1;
    localparam int MAX_VERT  = 16384;
    localparam int FRAC      = 14;
    localparam int RESET_IDX = 12;

    // squares accumulate into ACC_W; root operand is the sum shifted by 16
    localparam int ACC_W     = 2 * SUM_W + 1;
    localparam int REM_W     = ACC_W + 16;
    localparam int ROOT_W    = 25;
    localparam int DIV_W     = ROOT_W + 16;
    localparam int Q_W       = 16;

    localparam logic ITEM_VERTEX   = 1'b0;
    localparam logic ITEM_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] mid;
    } t_entry;

endpackage

/* hw/rtl/sphere_mesh_midpoint_subdivider.sv */
// ----------------------------------------------------------------------------
// sphere_mesh_midpoint_subdivider
// One pass of icosphere midpoint subdivision with a linear-search edge table
// and a shared sequencer for squaring, square root and division.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   three corner indices and xyz
// out      output     o_out_valid / i_out_ready item kind, indices, xyz, flags
// cfg      input      i_cfg_valid / o_cfg_ready first_new_index
//
// Per edge the table search reads each stored entry from the registered RAM
// and then compares it. A miss adds the squaring of the three sums, 25 root
// steps and a rounded, saturating restoring division per component.
// Four triangle transactions follow, one per cycle when out is not stalled.
// A config write resets the fill count, so no clearing pass is needed.
// Reset is synchronous, active low; in and cfg are taken only when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_mesh_midpoint_subdivider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sms_pkg::IDX_W-1:0]       i_corner_a_index,
    input  logic [sms_pkg::IDX_W-1:0]       i_corner_b_index,
    input  logic [sms_pkg::IDX_W-1:0]       i_corner_c_index,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_a_x,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_a_y,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_a_z,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_b_x,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_b_y,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_b_z,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_c_x,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_c_y,
    input  logic signed [sms_pkg::CRD_W-1:0] i_corner_c_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_item_kind,
    output logic [sms_pkg::IDX_W-1:0]       o_index_first,
    output logic [sms_pkg::IDX_W-1:0]       o_index_second,
    output logic [sms_pkg::IDX_W-1:0]       o_index_third,
    output logic signed [sms_pkg::CRD_W-1:0] o_vertex_x,
    output logic signed [sms_pkg::CRD_W-1:0] o_vertex_y,
    output logic signed [sms_pkg::CRD_W-1:0] o_vertex_z,
    output logic                            o_error_flag,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sms_pkg::IDX_W-1:0]       i_cfg_first_new_index
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQINI = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DCHK  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DFIN  = 4'd8;
    localparam logic [3:0] S_VEMIT = 4'd9;
    localparam logic [3:0] S_TEMIT = 4'd10;

    localparam int IW = sms_pkg::IDX_W;
    localparam int CW = sms_pkg::CRD_W;
    localparam int SW = sms_pkg::SUM_W;

    logic [3:0]                     r_state, n_state;
    logic [sms_pkg::NEXT_W-1:0]     r_next, n_next;
    logic [sms_pkg::CNT_W-1:0]      r_count, n_count;
    logic [sms_pkg::CNT_W-1:0]      r_addr, n_addr;
    logic [1:0]                     r_edge, n_edge;
    logic [1:0]                     r_comp, n_comp;
    logic [1:0]                     r_tri, n_tri;
    logic [4:0]                     r_cnt, n_cnt;
    logic                           r_face_err, n_face_err;
    logic                           r_verr, n_verr;
    logic                           r_ovf, n_ovf;

    // corner working copies, rotated once per edge
    logic [IW-1:0]                  r_wi [3], n_wi [3];
    logic signed [CW-1:0]           r_wx [3], n_wx [3];
    logic signed [CW-1:0]           r_wy [3], n_wy [3];
    logic signed [CW-1:0]           r_wz [3], n_wz [3];
    logic [IW-1:0]                  r_mid [3], n_mid [3];
    logic signed [SW-1:0]           r_s [3], n_s [3];
    logic signed [CW-1:0]           r_v [3], n_v [3];

    logic [sms_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [sms_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [sms_pkg::REM_W-1:0]      r_root, n_root;
    logic [sms_pkg::REM_W-1:0]      r_bit, n_bit;
    logic [sms_pkg::DIV_W-1:0]      r_num, n_num;
    logic [sms_pkg::DIV_W-1:0]      r_dsr, n_dsr;
    logic [sms_pkg::Q_W-1:0]        r_q, n_q;

    logic                           r_ov, n_ov;
    logic                           r_kind, n_kind;
    logic [IW-1:0]                  r_i1, n_i1, r_i2, n_i2, r_i3, n_i3;
    logic signed [CW-1:0]           r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic                           r_oerr, n_oerr, r_olast, n_olast;

    sms_pkg::t_entry                r_mem [sms_pkg::TBL_DEPTH];
    sms_pkg::t_entry                r_rd;
    sms_pkg::t_entry                w_wdata;
    logic                           w_we;
    logic                           w_re;

    logic [IW-1:0]                  w_lo, w_hi;
    logic                           w_free;
    logic                           w_full;
    logic [sms_pkg::ROOT_W-1:0]     w_len;
    logic signed [2*SW-1:0]         w_sq;
    logic [SW-1:0]                  w_mag;
    logic [sms_pkg::DIV_W-1:0]      w_num0;
    logic [sms_pkg::DIV_W-1:0]      w_lim;
    logic [sms_pkg::REM_W-1:0]      w_trial;
    logic signed [CW-1:0]           w_comp;
    logic                           w_cfg;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_cfg       = i_cfg_valid && o_cfg_ready;
    assign w_free      = !r_ov || i_out_ready;

    assign w_lo = (r_wi[0] < r_wi[1]) ? r_wi[0] : r_wi[1];
    assign w_hi = (r_wi[0] < r_wi[1]) ? r_wi[1] : r_wi[0];
    assign w_full = (r_count >= sms_pkg::CNT_W'(sms_pkg::TBL_DEPTH))
                 || (r_next >= sms_pkg::NEXT_W'(sms_pkg::MAX_VERT));

    assign w_len   = r_root[sms_pkg::ROOT_W-1:0];
    assign w_sq    = r_s[0] * r_s[0];
    assign w_mag   = r_s[0][SW-1] ? SW'(-r_s[0]) : SW'(r_s[0]);
    assign w_num0  = (sms_pkg::DIV_W'(w_mag) << (sms_pkg::FRAC + 8))
                   + sms_pkg::DIV_W'(w_len >> 1);
    assign w_lim   = sms_pkg::DIV_W'(w_len) << 16;
    assign w_trial = r_root + r_bit;

    assign w_wdata = '{lo: w_lo, hi: w_hi, mid: r_next[IW-1:0]};
    assign w_we    = (r_state == S_VEMIT) && w_free && !w_full;
    assign w_re    = (r_state == S_RD) && (r_addr != r_count);

    // rounded magnitude with sign and saturation
    always_comb begin
        if (r_s[0][SW-1]) begin
            if (r_ovf || r_q > 16'd32768) begin
                w_comp = 16'sh8000;
            end else begin
                w_comp = CW'(16'd0 - r_q);
            end
        end else begin
            if (r_ovf || r_q[sms_pkg::Q_W-1]) begin
                w_comp = 16'sh7FFF;
            end else begin
                w_comp = CW'(r_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[sms_pkg::TBL_AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_addr[sms_pkg::TBL_AW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;   n_next = r_next;     n_count = r_count;
        n_addr = r_addr;     n_edge = r_edge;     n_comp = r_comp;
        n_tri = r_tri;       n_cnt = r_cnt;       n_face_err = r_face_err;
        n_verr = r_verr;     n_ovf = r_ovf;
        n_wi = r_wi; n_wx = r_wx; n_wy = r_wy; n_wz = r_wz;
        n_mid = r_mid; n_s = r_s; n_v = r_v;
        n_acc = r_acc; n_rem = r_rem; n_root = r_root; n_bit = r_bit;
        n_num = r_num; n_dsr = r_dsr; n_q = r_q;
        n_ov = r_ov; n_kind = r_kind; n_i1 = r_i1; n_i2 = r_i2; n_i3 = r_i3;
        n_ox = r_ox; n_oy = r_oy; n_oz = r_oz; n_oerr = r_oerr; n_olast = r_olast;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        if (w_cfg) begin
            n_next  = sms_pkg::NEXT_W'(i_cfg_first_new_index);
            n_count = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_wi = '{i_corner_a_index, i_corner_b_index, i_corner_c_index};
                    n_wx = '{i_corner_a_x, i_corner_b_x, i_corner_c_x};
                    n_wy = '{i_corner_a_y, i_corner_b_y, i_corner_c_y};
                    n_wz = '{i_corner_a_z, i_corner_b_z, i_corner_c_z};
                    n_face_err = 1'b0;
                    n_edge  = '0;
                    n_addr  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_addr == r_count) begin
                    n_s[0] = SW'(r_wx[0]) + SW'(r_wx[1]);
                    n_s[1] = SW'(r_wy[0]) + SW'(r_wy[1]);
                    n_s[2] = SW'(r_wz[0]) + SW'(r_wz[1]);
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_rd.lo == w_lo && r_rd.hi == w_hi) begin
                    n_mid = '{r_mid[1], r_mid[2], r_rd.mid};
                    n_wi = '{r_wi[1], r_wi[2], r_wi[0]};
                    n_wx = '{r_wx[1], r_wx[2], r_wx[0]};
                    n_wy = '{r_wy[1], r_wy[2], r_wy[0]};
                    n_wz = '{r_wz[1], r_wz[2], r_wz[0]};
                    n_edge = r_edge + 2'd1;
                    n_addr = '0;
                    n_tri  = '0;
                    n_state = (r_edge == 2'd2) ? S_TEMIT : S_RD;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SQ: begin
                n_acc = r_acc + sms_pkg::ACC_W'(unsigned'(w_sq));
                n_s   = '{r_s[1], r_s[2], r_s[0]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_state = S_SQINI;
                end
            end
            S_SQINI: begin
                n_comp = '0;
                if (r_acc == '0) begin
                    n_v     = '{16'sd0, 16'sd0, 16'sd0};
                    n_verr  = 1'b1;
                    n_state = S_VEMIT;
                end else begin
                    n_verr  = 1'b0;
                    n_rem   = sms_pkg::REM_W'(r_acc) << 16;
                    n_root  = '0;
                    n_bit   = sms_pkg::REM_W'(1) << 48;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_rem >= w_trial) begin
                    n_rem  = r_rem - w_trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == sms_pkg::REM_W'(1)) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                n_num = w_num0;
                n_dsr = sms_pkg::DIV_W'(w_len) << 15;
                n_q   = '0;
                n_cnt = '0;
                n_ovf = (w_num0 >= w_lim);
                n_state = (w_num0 >= w_lim) ? S_DFIN : S_DIV;
            end
            S_DIV: begin
                if (r_num >= r_dsr) begin
                    n_num = r_num - r_dsr;
                end
                n_q   = {r_q[sms_pkg::Q_W-2:0], (r_num >= r_dsr)};
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(sms_pkg::Q_W - 1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                n_v    = '{r_v[1], r_v[2], w_comp};
                n_s    = '{r_s[1], r_s[2], r_s[0]};
                n_comp = r_comp + 2'd1;
                n_state = (r_comp == 2'd2) ? S_VEMIT : S_DCHK;
            end
            S_VEMIT: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_kind  = sms_pkg::ITEM_VERTEX;
                    n_i1    = w_full ? '0 : r_next[IW-1:0];
                    n_i2    = '0;
                    n_i3    = '0;
                    n_ox    = r_v[0];
                    n_oy    = r_v[1];
                    n_oz    = r_v[2];
                    n_oerr  = r_verr || w_full;
                    n_olast = 1'b0;
                    if (w_full) begin
                        n_face_err = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_next  = r_next + 1'b1;
                    end
                    n_mid = '{r_mid[1], r_mid[2], (w_full ? '0 : r_next[IW-1:0])};
                    n_wi = '{r_wi[1], r_wi[2], r_wi[0]};
                    n_wx = '{r_wx[1], r_wx[2], r_wx[0]};
                    n_wy = '{r_wy[1], r_wy[2], r_wy[0]};
                    n_wz = '{r_wz[1], r_wz[2], r_wz[0]};
                    n_edge = r_edge + 2'd1;
                    n_addr = '0;
                    n_tri  = '0;
                    n_state = (r_edge == 2'd2) ? S_TEMIT : S_RD;
                end
            end
            S_TEMIT: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_kind  = sms_pkg::ITEM_TRIANGLE;
                    n_ox    = '0;
                    n_oy    = '0;
                    n_oz    = '0;
                    n_oerr  = r_face_err;
                    n_olast = (r_tri == 2'd3);
                    case (r_tri)
                        2'd0: begin
                            n_i1 = r_wi[0];  n_i2 = r_mid[0]; n_i3 = r_mid[2];
                        end
                        2'd1: begin
                            n_i1 = r_mid[0]; n_i2 = r_wi[1];  n_i3 = r_mid[1];
                        end
                        2'd2: begin
                            n_i1 = r_mid[1]; n_i2 = r_wi[2];  n_i3 = r_mid[2];
                        end
                        default: begin
                            n_i1 = r_mid[0]; n_i2 = r_mid[1]; n_i3 = r_mid[2];
                        end
                    endcase
                    n_tri = r_tri + 2'd1;
                    if (r_tri == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next  <= sms_pkg::NEXT_W'(sms_pkg::RESET_IDX);
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;   r_edge <= n_edge;   r_comp <= n_comp;
        r_tri <= n_tri;     r_cnt <= n_cnt;     r_face_err <= n_face_err;
        r_verr <= n_verr;   r_ovf <= n_ovf;
        r_wi <= n_wi; r_wx <= n_wx; r_wy <= n_wy; r_wz <= n_wz;
        r_mid <= n_mid; r_s <= n_s; r_v <= n_v;
        r_acc <= n_acc; r_rem <= n_rem; r_root <= n_root; r_bit <= n_bit;
        r_num <= n_num; r_dsr <= n_dsr; r_q <= n_q;
        r_kind <= n_kind; r_i1 <= n_i1; r_i2 <= n_i2; r_i3 <= n_i3;
        r_ox <= n_ox; r_oy <= n_oy; r_oz <= n_oz;
        r_oerr <= n_oerr; r_olast <= n_olast;
    end

    assign o_out_valid    = r_ov;
    assign o_item_kind    = r_kind;
    assign o_index_first  = r_i1;
    assign o_index_second = r_i2;
    assign o_index_third  = r_i3;
    assign o_vertex_x     = r_ox;
    assign o_vertex_y     = r_oy;
    assign o_vertex_z     = r_oz;
    assign o_error_flag   = r_oerr;
    assign o_last_of_run  = r_olast;

    `CHECK_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= sms_pkg::CNT_W'(sms_pkg::TBL_DEPTH), "edge count beyond table depth")
    `CHECK_ALWAYS(a_write_guard, i_clk, i_rst_n,
        !w_we || (r_count < sms_pkg::CNT_W'(sms_pkg::TBL_DEPTH) && !r_next[IW]),
        "table write while full or at index limit")
    `CHECK_NEXT(a_sqrt_nonzero, i_clk, i_rst_n,
        r_state == S_SQINI && r_acc == '0, r_state == S_VEMIT,
        "zero-length sum entered the root unit")

endmodule

/* sim/sphere_mesh_midpoint_subdivider_test.sv */
// ----------------------------------------------------------------------------
// sphere_mesh_midpoint_subdivider_test
// Self-checking bench for one subdivision pass: faces go in, vertex and
// triangle transactions are predicted per face and compared in order, with
// random idle cycles on both channels and start-index writes between phases.
// ----------------------------------------------------------------------------
module sphere_mesh_midpoint_subdivider_test;

    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic [sms_pkg::IDX_W-1:0]        idx [3];
        logic signed [sms_pkg::CRD_W-1:0] crd [3][3];
    } t_face;

    typedef struct packed {
        logic                             kind;
        logic [sms_pkg::IDX_W-1:0]        first;
        logic [sms_pkg::IDX_W-1:0]        second;
        logic [sms_pkg::IDX_W-1:0]        third;
        logic signed [sms_pkg::CRD_W-1:0] x;
        logic signed [sms_pkg::CRD_W-1:0] y;
        logic signed [sms_pkg::CRD_W-1:0] z;
        logic                             err;
        logic                             last;
    } t_mesh_item;

    class t_mesh_scoreboard;
        logic [sms_pkg::IDX_W-1:0] edge_lo[$], edge_hi[$], edge_mid[$];
        int unsigned               next_index;
        t_mesh_item                pending[$];
        int                        mismatches;
        int                        faces, vertices, triangles, flagged;

        function void set_start(int unsigned start);
            next_index = start;
            edge_lo.delete(); edge_hi.delete(); edge_mid.delete();
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned rem, root, b;
            rem = n; root = 0; b = 64'd1 << 62;
            while (b > rem) b >>= 2;
            while (b != 0) begin
                if (rem >= root + b) begin
                    rem -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function logic signed [sms_pkg::CRD_W-1:0] scale_axis(int s,
                                                              longint unsigned len);
            longint unsigned mag, q;
            mag = (s < 0) ? longint'(-s) : longint'(s);
            q = ((mag << (sms_pkg::FRAC + 8)) + (len >> 1)) / len;
            if (s < 0) begin
                if (q > 32768) q = 32768;
                return sms_pkg::CRD_W'(-q);
            end
            if (q > 32767) q = 32767;
            return sms_pkg::CRD_W'(q);
        endfunction

        function void note_face(t_face f);
            logic [sms_pkg::IDX_W-1:0] mid [3];
            logic [sms_pkg::IDX_W-1:0] lo, hi;
            logic                      face_err, hit, err;
            int                        s [3];
            longint unsigned           nsq, len;
            t_mesh_item                it;
            int                        p, q;
            face_err = 0;
            faces++;
            for (int e = 0; e < 3; e++) begin
                p = e; q = (e + 1) % 3;
                lo = (f.idx[p] < f.idx[q]) ? f.idx[p] : f.idx[q];
                hi = (f.idx[p] < f.idx[q]) ? f.idx[q] : f.idx[p];
                hit = 0;
                foreach (edge_lo[i])
                    if (!hit && edge_lo[i] == lo && edge_hi[i] == hi) begin
                        hit = 1;
                        mid[e] = edge_mid[i];
                    end
                if (!hit) begin
                    it = '0;
                    nsq = 0;
                    err = 0;
                    for (int a = 0; a < 3; a++) begin
                        s[a] = int'(f.crd[p][a]) + int'(f.crd[q][a]);
                        nsq += longint'(s[a]) * longint'(s[a]);
                    end
                    if (nsq == 0) begin
                        err = 1;
                    end else begin
                        len = floor_sqrt(nsq << 16);
                        it.x = scale_axis(s[0], len);
                        it.y = scale_axis(s[1], len);
                        it.z = scale_axis(s[2], len);
                    end
                    if (edge_lo.size() >= sms_pkg::TBL_DEPTH
                        || next_index >= sms_pkg::MAX_VERT) begin
                        mid[e] = '0;
                        err = 1;
                        face_err = 1;
                    end else begin
                        mid[e] = sms_pkg::IDX_W'(next_index);
                        edge_lo = {edge_lo, lo};
                        edge_hi = {edge_hi, hi};
                        edge_mid = {edge_mid, mid[e]};
                        next_index++;
                    end
                    it.kind = sms_pkg::ITEM_VERTEX;
                    it.first = mid[e];
                    it.err = err;
                    pending = {pending, it};
                end
            end
            push_tri(f.idx[0], mid[0], mid[2], face_err, 0);
            push_tri(mid[0], f.idx[1], mid[1], face_err, 0);
            push_tri(mid[1], f.idx[2], mid[2], face_err, 0);
            push_tri(mid[0], mid[1], mid[2], face_err, 1);
        endfunction

        function void push_tri(logic [sms_pkg::IDX_W-1:0] a, logic [sms_pkg::IDX_W-1:0] b,
                               logic [sms_pkg::IDX_W-1:0] c, logic err, logic last);
            t_mesh_item it;
            it = '0;
            it.kind = sms_pkg::ITEM_TRIANGLE;
            it.first = a; it.second = b; it.third = c;
            it.err = err; it.last = last;
            pending = {pending, it};
        endfunction

        function void check_item(t_mesh_item got);
            t_mesh_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transaction %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind == sms_pkg::ITEM_VERTEX) vertices++; else triangles++;
            if (got.err) flagged++;
            if (got.kind !== want.kind || got.first !== want.first
                || got.second !== want.second || got.third !== want.third
                || got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.err !== want.err || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mismatch\n  exp %p\n  got %p", want, got);
            end
        endfunction
    endclass

    logic                             i_clk = 0;
    logic                             i_rst_n = 0;
    logic                             i_in_valid = 0;
    logic                             o_in_ready;
    logic [sms_pkg::IDX_W-1:0]        in_idx [3];
    logic signed [sms_pkg::CRD_W-1:0] in_crd [3][3];
    logic                             o_out_valid;
    logic                             i_out_ready = 0;
    wire t_mesh_item                  out_item;
    logic                             i_cfg_valid = 0;
    logic                             o_cfg_ready;
    logic [sms_pkg::IDX_W-1:0]        i_cfg_first_new_index = '0;

    t_mesh_scoreboard sb;
    bit               quiet;        // no idling on either side
    int               hold_cycles;  // receiver back-pressure request
    int               pool_base;

    initial begin
        foreach (in_idx[c]) in_idx[c] = '0;
        foreach (in_crd[c, a]) in_crd[c][a] = '0;
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    sphere_mesh_midpoint_subdivider dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_corner_a_index(in_idx[0]), .i_corner_b_index(in_idx[1]),
        .i_corner_c_index(in_idx[2]),
        .i_corner_a_x(in_crd[0][0]), .i_corner_a_y(in_crd[0][1]),
        .i_corner_a_z(in_crd[0][2]),
        .i_corner_b_x(in_crd[1][0]), .i_corner_b_y(in_crd[1][1]),
        .i_corner_b_z(in_crd[1][2]),
        .i_corner_c_x(in_crd[2][0]), .i_corner_c_y(in_crd[2][1]),
        .i_corner_c_z(in_crd[2][2]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_item_kind(out_item.kind), .o_index_first(out_item.first),
        .o_index_second(out_item.second), .o_index_third(out_item.third),
        .o_vertex_x(out_item.x), .o_vertex_y(out_item.y), .o_vertex_z(out_item.z),
        .o_error_flag(out_item.err), .o_last_of_run(out_item.last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_first_new_index(i_cfg_first_new_index)
    );

    // receiver: checks at each edge, then decides ready for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_item(out_item);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_face(t_face f);
        if (!quiet && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        in_idx <= f.idx;
        in_crd <= f.crd;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_face(f);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_start(int unsigned start);
        drain();
        i_cfg_valid <= 1;
        i_cfg_first_new_index <= sms_pkg::IDX_W'(start);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_start(start);
    endtask

    function automatic t_face make_face(int i0, int i1, int i2,
                                        int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
        t_face f;
        f.idx[0] = sms_pkg::IDX_W'(i0);
        f.idx[1] = sms_pkg::IDX_W'(i1);
        f.idx[2] = sms_pkg::IDX_W'(i2);
        f.crd[0][0] = sms_pkg::CRD_W'(ax);
        f.crd[0][1] = sms_pkg::CRD_W'(ay);
        f.crd[0][2] = sms_pkg::CRD_W'(az);
        f.crd[1][0] = sms_pkg::CRD_W'(bx);
        f.crd[1][1] = sms_pkg::CRD_W'(by);
        f.crd[1][2] = sms_pkg::CRD_W'(bz);
        f.crd[2][0] = sms_pkg::CRD_W'(cx);
        f.crd[2][1] = sms_pkg::CRD_W'(cy);
        f.crd[2][2] = sms_pkg::CRD_W'(cz);
        return f;
    endfunction

    // mostly faces over a small vertex pool so edges are shared; the rest
    // raw bit patterns and opposite-corner edges
    function automatic t_face random_face();
        t_face f;
        int    mode;
        mode = $urandom_range(0, 9);
        for (int c = 0; c < 3; c++) begin
            f.idx[c] = (mode >= 7)
                     ? sms_pkg::IDX_W'($urandom_range(0, 16383))
                     : sms_pkg::IDX_W'(pool_base + int'($urandom_range(0, 9)));
            for (int a = 0; a < 3; a++)
                f.crd[c][a] = (mode >= 7)
                            ? sms_pkg::CRD_W'($urandom())
                            : sms_pkg::CRD_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        if (mode == 9)
            for (int a = 0; a < 3; a++) f.crd[1][a] = -f.crd[0][a];
        return f;
    endfunction

    task automatic random_run(int count);
        pool_base = $urandom_range(0, 16373);
        repeat (count) send_face(random_face());
    endtask

    initial begin
        sb = new();
        sb.set_start(sms_pkg::RESET_IDX);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, zero-length midpoints, degenerate and shared edges
        send_face(make_face(0, 16383, 1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_face(make_face(16383, 0, 2, -16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_face(make_face(3, 4, 5, 32767, 32767, 32767, -32768, -32768, -32768,
                            16384, -16384, 0));
        send_face(make_face(6, 7, 8, 1000, -2000, 300, -1000, 2000, -300, 0, 0, 0));
        send_face(make_face(9, 9, 9, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        send_face(make_face(9, 9, 10, 1, 0, 0, 1, 0, 0, -1, 0, 0));
        send_face(make_face(4, 3, 11, 0, 16384, 0, 16384, 0, 0, -16384, 0, 0));
        send_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_face(make_face(11, 3, 4, -32768, 0, 0, -32768, 0, 0, 32767, 1, -1));
        send_face(make_face(5461, 10922, 8191, 11585, 11585, 0, -11585, 0, 11585,
                            0, -11585, -11585));

        write_start(0);
        random_run(40);

        // index limit: the first two allocations succeed, the rest fail
        write_start(16382);
        send_face(make_face(1, 2, 3, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_face(make_face(4, 5, 6, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_face(make_face(1, 2, 7, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        random_run(8);

        write_start(16383);
        send_face(make_face(20, 21, 22, 0, 0, 16384, 16384, 0, 0, 0, 0, -16384));
        send_face(make_face(20, 21, 23, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));

        write_start($urandom_range(13, 16000));
        random_run(20);
        hold_cycles = 400;  // output stalled while faces keep coming
        random_run(10);
        quiet = 1;
        random_run(20);
        quiet = 0;
        random_run(15);

        drain();
        $display("faces %0d: %0d vertex and %0d triangle transactions, %0d flagged",
                 sb.faces, sb.vertices, sb.triangles, sb.flagged);
        $display("start index rewritten between phases, index limit and stalls hit");
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("mismatches: %0d", sb.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
